// ----- hdl/spatial_cell_hash_3d_defines.svh -----
// spatial_cell_hash_3d_defines.svh: assertion macros shared by the hash rtl
// no dependencies
`ifndef SPATIAL_CELL_HASH_3D_DEFINES_SVH
`define SPATIAL_CELL_HASH_3D_DEFINES_SVH

// a implies b on the next clock edge, held off during reset
`define SCH_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// a implies b on the same clock edge, held off during reset
`define SCH_ASSERT_NOW(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`endif

// ----- hdl/sch_pkg.sv -----
// sch_pkg: constants and helpers shared by the spatial hash rtl
// no dependencies
`timescale 1ns / 1ps
package sch_pkg;
   localparam logic [31:0] HASH_PX = 32'd73856093;
   localparam logic [31:0] HASH_PY = 32'd19349663;
   localparam logic [31:0] HASH_PZ = 32'd83492791;
   localparam logic [31:0] CELL_SIZE_RESET  = 32'd65536;
   localparam logic [23:0] TABLE_SIZE_RESET = 24'd1;

   typedef enum logic {
      REG_CELL_SIZE  = 1'b0,
      REG_TABLE_SIZE = 1'b1
   } reg_index_type;
endpackage

// ----- hdl/sch_udiv_pipe.sv -----
// sch_udiv_pipe: unsigned restoring divider, one quotient bit per register stage
// depends on nothing; divisor must hold steady while beats are in flight
`timescale 1ns / 1ps
module sch_udiv_pipe #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quot,
   output logic [DEN_W-1:0]  rem,
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  bits_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   genvar i;
   generate
      for (i = 0; i < NUM_W; i++) begin : g_stage
         logic              src_valid;
         logic [DEN_W-1:0]  src_rem;
         logic [NUM_W-1:0]  src_bits;
         logic [SIDE_W-1:0] src_side;
         logic [DEN_W:0]    trial;
         logic [DEN_W:0]    diff;
         logic              ge;
         logic [DEN_W-1:0]  rem_in;
         logic [NUM_W-1:0]  bits_in;

         // stage source: ports for the first stage, previous stage otherwise
         if (i == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_bits  = num;
            assign src_side  = in_side;
         end else begin : g_next
            assign src_valid = valid_ff[i-1];
            assign src_rem   = rem_ff[i-1];
            assign src_bits  = bits_ff[i-1];
            assign src_side  = side_ff[i-1];
         end

         // one restoring step, quotient bit shifts in at the bottom
         always_comb begin
            trial   = {src_rem, src_bits[NUM_W-1]};
            diff    = trial - {1'b0, den};
            ge      = (trial >= {1'b0, den});
            rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_in = {src_bits[NUM_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i]  <= rem_in;
               bits_ff[i] <= bits_in;
               side_ff[i] <= src_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NUM_W-1];
   assign quot      = bits_ff[NUM_W-1];
   assign rem       = rem_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule

// ----- hdl/spatial_cell_hash_3d.sv -----
// spatial_cell_hash_3d: streaming 3d spatial hash of a point to a bucket
// depends on sch_pkg, sch_udiv_pipe and spatial_cell_hash_3d_defines.svh
//
// usage
//   req channel: one beat per point, signed q15.16 pos_x, pos_y, pos_z.
//   rsp channel: one beat per point, bucket in 0 .. table_size-1 (0 if table_size is 0), in order.
//   csr port: apb-style, cell_size at byte 0, table_size at byte 4; write
//   only while no beat is in flight.
// pipeline: 69 register stages from the req accept edge to rsp valid
//   (input register, 32 cell-index divider stages,
//   fixup, multiply, xor, 32 modulo divider stages, output register).
// throughput: one beat per cycle while not stalled; the two bit-per-stage
//   divider pipelines set the depth, not the rate.
// stall: while rsp holds a beat under rsp_stall, the whole pipeline
//   freezes and req_stall is raised; nothing is lost or repeated.
// reset: empties the pipeline, cell_size goes to 1.0, table_size to 1.
`timescale 1ns / 1ps
`include "spatial_cell_hash_3d_defines.svh"
module spatial_cell_hash_3d
   import sch_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_bucket,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   logic [31:0] cell_size_ff;
   logic [23:0] table_size_ff;
   logic        en;

   // csr registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff  <= CELL_SIZE_RESET;
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_CELL_SIZE:  cell_size_ff  <= csr_pwdata;
            REG_TABLE_SIZE: table_size_ff <= csr_pwdata[23:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_CELL_SIZE:  csr_prdata = cell_size_ff;
         REG_TABLE_SIZE: csr_prdata = {8'd0, table_size_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // global advance: freeze everything while the output beat is held
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // input register
   logic        in_valid_ff;
   logic [31:0] pos_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
   end

   // cell index lanes: magnitude divide, then floor and sign fixup
   logic        div_valid [3];
   logic [31:0] div_quot  [3];
   logic [31:0] div_rem   [3];
   logic [1:0]  div_side  [3];
   logic        fix_valid_ff;
   logic [31:0] idx_ff    [3];
   logic [31:0] idx_in    [3];
   logic        mul_valid_ff;
   logic [31:0] prod_ff   [3];
   logic [31:0] hash_mult [3];

   assign hash_mult[0] = HASH_PX;
   assign hash_mult[1] = HASH_PY;
   assign hash_mult[2] = HASH_PZ;

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_lane
         logic        neg;
         logic        nonzero;
         logic [31:0] mag;

         assign neg     = pos_ff[k][31];
         assign nonzero = (pos_ff[k] != 32'd0);
         assign mag     = neg ? (32'd0 - pos_ff[k]) : pos_ff[k];

         sch_udiv_pipe #(.NUM_W(32), .DEN_W(32), .SIDE_W(2)) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (in_valid_ff),
            .num       (mag),
            .den       (cell_size_ff),
            .in_side   ({neg, nonzero}),
            .out_valid (div_valid[k]),
            .quot      (div_quot[k]),
            .rem       (div_rem[k]),
            .out_side  (div_side[k])
         );

         // floor toward minus infinity, zero divisor saturates
         always_comb begin
            if (cell_size_ff == 32'd0) begin
               if (!div_side[k][0]) begin
                  idx_in[k] = 32'd0;
               end else if (div_side[k][1]) begin
                  idx_in[k] = 32'h8000_0000;
               end else begin
                  idx_in[k] = 32'h7FFF_FFFF;
               end
            end else if (div_side[k][1]) begin
               idx_in[k] = (div_rem[k] != 32'd0) ? ~div_quot[k]
                                                 : (32'd0 - div_quot[k]);
            end else begin
               idx_in[k] = div_quot[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               idx_ff[k]  <= idx_in[k];
               prod_ff[k] <= 32'(idx_ff[k] * hash_mult[k]);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         fix_valid_ff <= div_valid[0];
         mul_valid_ff <= fix_valid_ff;
      end
   end

   // xor of products, split into sign and magnitude
   logic        xor_valid_ff;
   logic        hneg_ff;
   logic [31:0] hmag_ff;
   logic [31:0] hash_in;
   assign hash_in = prod_ff[0] ^ prod_ff[1] ^ prod_ff[2];
   always_ff @(posedge clock) begin
      if (reset) begin
         xor_valid_ff <= 1'b0;
      end else if (en) begin
         xor_valid_ff <= mul_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hneg_ff <= hash_in[31];
         hmag_ff <= hash_in[31] ? (32'd0 - hash_in) : hash_in;
      end
   end

   // modulo by table size
   logic        mod_valid;
   logic [31:0] mod_quot;
   logic [23:0] mod_rem;
   logic [0:0]  mod_side;
   sch_udiv_pipe #(.NUM_W(32), .DEN_W(24), .SIDE_W(1)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xor_valid_ff),
      .num       (hmag_ff),
      .den       (table_size_ff),
      .in_side   (hneg_ff),
      .out_valid (mod_valid),
      .quot      (mod_quot),
      .rem       (mod_rem),
      .out_side  (mod_side)
   );

   // non-negative remainder into the output register
   logic [23:0] bucket_in;
   logic [23:0] bucket_ff;
   always_comb begin
      if (table_size_ff == 24'd0) begin
         bucket_in = 24'd0;
      end else if (mod_side[0] && (mod_rem != 24'd0)) begin
         bucket_in = table_size_ff - mod_rem;
      end else begin
         bucket_in = mod_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mod_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         bucket_ff <= bucket_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bucket = bucket_ff;

   // quotient of the modulo divider is not needed beyond its remainder
   logic unused_quot;
   assign unused_quot = ^mod_quot;

   `SCH_ASSERT_NOW(a_bucket_range, clock, reset, rsp_valid && (table_size_ff != 24'd0), rsp_bucket < table_size_ff, "bucket out of range")
   `SCH_ASSERT_NOW(a_zero_table, clock, reset, rsp_valid && (table_size_ff == 24'd0), rsp_bucket == 24'd0, "bucket nonzero with zero table")
   `SCH_ASSERT_NEXT(a_freeze, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(mod_valid) && $stable(xor_valid_ff), "pipeline moved while output held")
   `SCH_ASSERT_NOW(a_lanes_aligned, clock, reset, 1'b1, (div_valid[1] == div_valid[0]) && (div_valid[2] == div_valid[0]), "cell index lanes out of step")
endmodule
